FILE: design/pixhist_pkg.sv
// Package for the pixel histogram block: command and result transaction types,
// plus the opcode constants. No dependencies.
`timescale 1ns / 1ps

package pixhist_pkg;

    // Operation codes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam int SAMPLE_BITS = 8;
    localparam int OUT_COUNT_BITS = 32;

    // Fixed tracker reset values
    localparam logic [SAMPLE_BITS-1:0] MIN_RESET = '1;
    localparam logic [SAMPLE_BITS-1:0] MAX_RESET = '0;

    typedef struct packed {
        logic                   opcode;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   first_of_image;
    } t_cmd;

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] bin_count;
        logic [SAMPLE_BITS-1:0]    min_sample;
        logic [SAMPLE_BITS-1:0]    max_sample;
        logic [OUT_COUNT_BITS-1:0] peak_count;
        logic                      empty_res;
    } t_result;

endpackage

FILE: design/pixel_histogram_min_max.sv
// Pixel histogram with min/max/peak tracking: top level, bin memory and trackers.
// Depends on pixhist_pkg for the transaction types and opcodes.
`timescale 1ns / 1ps

// Usage
// -----
// Command channel: a transaction is taken at a rising edge with i_start high and
// o_busy low. o_busy is always low, so one sample can be counted every clock.
// i_cmd.opcode selects counting the sample into its bin or reading the bin that
// i_cmd.sample addresses. first_of_image on a count clears all bins and the
// min/max/peak trackers before that sample is counted; on a read it is ignored.
// Result channel: every command yields exactly one result, shown on o_result for
// one cycle with o_result_valid high. A command is registered into stage 1 at
// accept and its result then into the result register, with throughput one
// transaction per cycle. The rate is set by the bin memory: one read port, read
// at accept, and one write port, written in the cycle after; a back-to-back count
// of the same bin is served by a forwarding register.
// The receiver cannot stall; results are never held.
// Reset (synchronous, active low) clears the per-bin valid bits at once, so
// every bin reads zero right after reset with no clearing pass; trackers go to
// min 255, max 0, peak 0, empty. Bins count up and saturate at all-ones.
// Bins at or above LEVELS do not exist: counts to them are dropped and reads
// return zero.

module pixel_histogram_min_max
    import pixhist_pkg::*;
#(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_result_valid,
    output t_result o_result
);

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Bin storage (no reset; qualified by valid bits)
    logic [COUNT_BITS-1:0] r_mem [LEVELS];
    logic [LEVELS-1:0]     r_valid;
    logic [LEVELS-1:0]     n_valid;

    // Stage 1: command register and registered memory read
    logic                  r_s1_valid;
    t_cmd                  r_s1_cmd;
    logic [COUNT_BITS-1:0] r_rd_data;

    // Forwarding of the write made in the previous cycle
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;

    // Trackers
    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [COUNT_BITS-1:0]  r_peak, n_peak;
    logic                   r_empty, n_empty;

    // Result register
    logic    r_res_valid;
    t_result r_res;

    logic                  accept;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         s1_addr;
    logic                  s1_in_range;
    logic                  s1_is_count;
    logic                  s1_clear;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [COUNT_BITS-1:0] res_cnt;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;
    assign rd_addr = AW'(i_cmd.sample);

    assign s1_addr     = AW'(r_s1_cmd.sample);
    assign s1_in_range = (32'(r_s1_cmd.sample) < LEVELS);
    assign s1_is_count = r_s1_valid && (r_s1_cmd.opcode == OP_COUNT);
    assign s1_clear    = s1_is_count && r_s1_cmd.first_of_image;
    assign wr_en       = s1_is_count && s1_in_range;

    // Current bin value seen by this transaction (before its own count)
    always_comb begin
        if (!s1_in_range || s1_clear || !r_valid[s1_addr]) begin
            old_cnt = '0;
        end else if (r_fwd_valid && (r_fwd_addr == s1_addr)) begin
            old_cnt = r_fwd_data;
        end else begin
            old_cnt = r_rd_data;
        end
    end

    assign new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
    assign res_cnt = wr_en ? new_cnt : old_cnt;

    always_comb begin
        n_valid = r_valid;
        n_min   = r_min;
        n_max   = r_max;
        n_peak  = r_peak;
        n_empty = r_empty;
        if (s1_clear) begin
            n_valid = '0;
            n_min   = MIN_RESET;
            n_max   = MAX_RESET;
            n_peak  = '0;
            n_empty = 1'b1;
        end
        if (wr_en) begin
            n_valid[s1_addr] = 1'b1;
            n_empty = 1'b0;
            if (new_cnt > n_peak) begin
                n_peak = new_cnt;
            end
            if (r_s1_cmd.sample < n_min) begin
                n_min = r_s1_cmd.sample;
            end
            if (r_s1_cmd.sample > n_max) begin
                n_max = r_s1_cmd.sample;
            end
        end
    end

    // Bin memory: one read port at accept, one write port in stage 2
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[s1_addr] <= new_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd <= i_cmd;
        end
        r_fwd_addr <= s1_addr;
        r_fwd_data <= new_cnt;
        r_res.bin_count  <= OUT_COUNT_BITS'(res_cnt);
        r_res.min_sample <= n_min;
        r_res.max_sample <= n_max;
        r_res.peak_count <= OUT_COUNT_BITS'(n_peak);
        r_res.empty_res  <= n_empty;
    end

    // Control state and trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_res_valid <= 1'b0;
            r_valid     <= '0;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_peak      <= '0;
            r_empty     <= 1'b1;
        end else begin
            r_s1_valid  <= accept;
            r_fwd_valid <= wr_en;
            r_res_valid <= r_s1_valid;
            r_valid     <= n_valid;
            r_min       <= n_min;
            r_max       <= n_max;
            r_peak      <= n_peak;
            r_empty     <= n_empty;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    // Every accepted command produces its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_result_valid)
        else $error("result strobe missing two cycles after accept");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, 2))
        else $error("result strobe without a command");

    // Once something was counted, min never exceeds max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.empty_res) |->
            (o_result.min_sample <= o_result.max_sample))
        else $error("min above max on a non-empty histogram");

    // Empty histogram: all bins and the peak read zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.empty_res) |->
            (o_result.peak_count == '0 && o_result.bin_count == '0))
        else $error("nonzero count on an empty histogram");

    // A count that starts an image always lands at one
    a_first_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_clear && s1_in_range) |-> (new_cnt == COUNT_BITS'(1)))
        else $error("first count of an image not equal to one");

endmodule
